// ===== hdl/hgi_pkg.sv =====
// ============================================================================
// Hexalinear grid interpolator package
// Shared types, constants and saturation helpers for the interpolator.
// ============================================================================
package hgi_pkg;

    localparam int NUM_AXES        = 6;
    localparam int IDX_BITS        = 2;
    localparam int ADDR_BITS       = 12;
    localparam int DATA_W          = 32;
    localparam int CFG_W           = 3;
    localparam int CFG_IDX_W       = 3;
    localparam int QUEUE_DEPTH     = 2;
    localparam int DEF_AXIS_POINTS = 4;
    localparam int DEF_FRAC_BITS   = 16;
    localparam int WIDE_W          = 66;

    localparam logic [CFG_W-1:0] POINTS_RESET = 3'd4;

    localparam logic [1:0] ACT_COORD = 2'd0;
    localparam logic [1:0] ACT_TABLE = 2'd1;
    localparam logic [1:0] ACT_QUERY = 2'd2;

    typedef struct packed {
        logic [1:0]              action;
        logic [2:0]              axis;
        logic [1:0]              point_index;
        logic [ADDR_BITS-1:0]    table_address;
        logic signed [DATA_W-1:0] write_value;
        logic signed [DATA_W-1:0] query_x0;
        logic signed [DATA_W-1:0] query_x1;
        logic signed [DATA_W-1:0] query_x2;
        logic signed [DATA_W-1:0] query_x3;
        logic signed [DATA_W-1:0] query_x4;
        logic signed [DATA_W-1:0] query_x5;
    } in_word_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] interpolated;
        logic                     extrapolated;
        logic                     degenerate_cell;
    } out_word_t;

    typedef enum logic [1:0] {
        OP_COORD,
        OP_TABLE,
        OP_QUERY
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t  op;
        in_word_t word;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
    } queue_status_t;

    typedef logic [NUM_AXES-1:0][CFG_W-1:0] points_t;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > 66'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end
        else if (v < -66'sd2147483648) begin
            r = 32'sh8000_0000;
        end
        else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== hdl/hgi_front.sv =====
// ============================================================================
// Interpolator front end
// Accepts command words and sorts them into coordinate writes, table writes
// and queries; words that change nothing are dropped here.
// ============================================================================
module hgi_front import hgi_pkg::*;
#(
    parameter int AXIS_POINTS = DEF_AXIS_POINTS
)
(
    input  logic     start,
    input  logic     busy,
    input  in_word_t item,
    output logic     push,
    output cmd_t     cmd
);

    logic accept;
    logic coord_ok;

    assign accept   = start && !busy;
    assign coord_ok = (int'(item.axis) < NUM_AXES) && (int'(item.point_index) < AXIS_POINTS);

    always_comb
    begin
        cmd.word = item;
        cmd.op   = OP_QUERY;
        push     = 1'b0;
        case (item.action)
            ACT_COORD:
            begin
                cmd.op = OP_COORD;
                push   = accept && coord_ok;
            end
            ACT_TABLE:
            begin
                cmd.op = OP_TABLE;
                push   = accept;
            end
            ACT_QUERY:
            begin
                cmd.op = OP_QUERY;
                push   = accept;
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

endmodule

// ===== hdl/hgi_queue.sv =====
// ============================================================================
// Command queue
// A short first-in first-out buffer between the front end and the sequencer.
// ============================================================================
module hgi_queue import hgi_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  cmd_t          push_cmd,
    input  logic          pop,
    output cmd_t          head,
    output queue_status_t status
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    cmd_t            entry_reg [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;

    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == CW'(QUEUE_DEPTH));
    assign head         = entry_reg[rd_ptr_reg];
    assign count_next   = count_reg + CW'(push) - CW'(pop);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

// ===== hdl/hgi_div.sv =====
// ============================================================================
// Weight divider
// Restoring divider, one quotient bit a cycle, giving the rounded and
// saturated left weight ((right - x) << F) / (right - left).
// ============================================================================
module hgi_div import hgi_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [DATA_W:0]   num,
    input  logic signed [DATA_W:0]   den,
    output logic                     busy,
    output logic                     done,
    output logic signed [DATA_W-1:0] quot
);

    localparam int NW  = DATA_W + 2 + FRAC_BITS;
    localparam int DW  = DATA_W + 1;
    localparam int RW  = DW + 2;
    localparam int CNW = $clog2(NW + 1);

    logic [DW-1:0]   num_mag;
    logic [DW-1:0]   den_mag;
    logic [NW-1:0]   dividend_reg;
    logic [NW-1:0]   quo_reg;
    logic [DW-1:0]   den_reg;
    logic [RW-1:0]   rem_reg;
    logic [RW-1:0]   rem_sh;
    logic            fits;
    logic [CNW-1:0]  cnt_reg;
    logic            neg_reg;
    logic            busy_reg;
    logic            done_reg;
    logic signed [DATA_W-1:0] quot_reg;
    logic signed [DATA_W-1:0] sat_val;

    assign num_mag = num[DATA_W] ? DW'(-num) : DW'(num);
    assign den_mag = den[DATA_W] ? DW'(-den) : DW'(den);
    assign rem_sh  = {rem_reg[RW-2:0], dividend_reg[NW-1]};
    assign fits    = (rem_sh >= RW'(den_reg));

    always_comb
    begin
        if (!neg_reg)
        begin
            if (quo_reg > NW'(32'h7FFF_FFFF))
            begin
                sat_val = 32'sh7FFF_FFFF;
            end
            else
            begin
                sat_val = quo_reg[DATA_W-1:0];
            end
        end
        else
        begin
            if (quo_reg > NW'(32'h8000_0000))
            begin
                sat_val = 32'sh8000_0000;
            end
            else
            begin
                sat_val = ~quo_reg[DATA_W-1:0] + 32'sd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dividend_reg <= (NW'(num_mag) << FRAC_BITS) + NW'(den_mag >> 1);
            den_reg      <= den_mag;
            neg_reg      <= num[DATA_W] ^ den[DATA_W];
            rem_reg      <= '0;
            quo_reg      <= '0;
        end
        else if (busy_reg && (cnt_reg != CNW'(NW)))
        begin
            dividend_reg <= dividend_reg << 1;
            rem_reg      <= fits ? (rem_sh - RW'(den_reg)) : rem_sh;
            quo_reg      <= {quo_reg[NW-2:0], fits};
        end
        if (busy_reg && (cnt_reg == CNW'(NW)))
        begin
            quot_reg <= sat_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == CNW'(NW))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg + CNW'(1);
                end
            end
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// ===== hdl/hgi_back.sv =====
// ============================================================================
// Interpolator sequencer
// Carries out queued commands: stores coordinates and table values, and for
// a query finds the cell and weights per axis, then sums the 64 corners.
// ============================================================================
module hgi_back import hgi_pkg::*;
#(
    parameter int AXIS_POINTS = DEF_AXIS_POINTS,
    parameter int FRAC_BITS   = DEF_FRAC_BITS
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  queue_status_t q_status,
    input  cmd_t          q_head,
    output logic          pop,
    input  points_t       points,
    output logic          result_valid,
    output out_word_t     result
);

    localparam int COORD_DEPTH = NUM_AXES * AXIS_POINTS;
    localparam int CA_W        = $clog2(COORD_DEPTH);
    localparam int MAX_USED    = (AXIS_POINTS < 4) ? AXIS_POINTS : 4;
    localparam int ACCW        = 71 - FRAC_BITS;
    localparam int TAB_DEPTH   = 1 << ADDR_BITS;
    localparam logic signed [DATA_W-1:0] ONE = 32'sd1 <<< FRAC_BITS;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_PT_RD,
        S_PT_USE,
        S_LFT_RD,
        S_LFT_USE,
        S_RGT_USE,
        S_DIV,
        S_AXIS_END,
        S_C_START,
        S_C_MUL,
        S_C_ACC,
        S_DONE
    } state_t;

    state_t                   state_reg;
    cmd_t                     cmd_reg;
    logic [2:0]               axis_reg;
    logic [2:0]               pt_reg;
    logic [2:0]               below_reg;
    logic [1:0]               cur_cell_reg;
    logic [1:0]               cell_reg [NUM_AXES];
    logic signed [DATA_W-1:0] wl_reg [NUM_AXES];
    logic signed [DATA_W-1:0] wr_reg [NUM_AXES];
    logic signed [DATA_W-1:0] lft_reg;
    logic signed [DATA_W-1:0] w_reg;
    logic signed [ACCW-1:0]   acc_reg;
    logic [5:0]               corner_reg;
    logic [2:0]               step_reg;
    logic                     extra_reg;
    logic                     degen_reg;
    logic                     result_valid_reg;
    out_word_t                result_reg;

    logic signed [DATA_W-1:0] coord_mem [COORD_DEPTH];
    logic signed [DATA_W-1:0] coord_q_reg;
    logic signed [DATA_W-1:0] table_mem [TAB_DEPTH];
    logic signed [DATA_W-1:0] tab_q_reg;

    logic [2:0]               n_raw;
    logic [2:0]               n_cur;
    logic [2:0]               cell_now;
    logic signed [DATA_W-1:0] x_cur;
    logic [2:0]               pt_sel;
    logic [CA_W-1:0]          coord_addr;
    logic [CA_W-1:0]          coord_waddr;
    logic                     coord_we;
    logic [ADDR_BITS-1:0]     tidx;
    logic [ADDR_BITS-1:0]     tab_addr;
    logic                     tab_we;
    logic                     tab_re;
    logic signed [DATA_W-1:0] wsel;
    logic signed [DATA_W-1:0] wl_new;
    logic signed [DATA_W-1:0] wr_new;
    logic                     div_start;
    logic                     div_busy;
    logic                     div_done;
    logic signed [DATA_W-1:0] div_quot;
    logic signed [DATA_W:0]   div_num;
    logic signed [DATA_W:0]   div_den;

    // Rounded product a*b / 2^F, half up, not saturated.
    function automatic logic signed [WIDE_W-1:0] qmul(input logic signed [DATA_W-1:0] a,
                                                       input logic signed [DATA_W-1:0] b);
        logic signed [WIDE_W-1:0] p;
        p = WIDE_W'(a) * WIDE_W'(b);
        p = p + (66'sd1 <<< (FRAC_BITS - 1));
        return p >>> FRAC_BITS;
    endfunction

    assign n_raw = points[axis_reg];

    always_comb
    begin
        n_cur = n_raw;
        if (n_raw < 3'd2)
        begin
            n_cur = 3'd2;
        end
        if (n_raw > 3'(MAX_USED))
        begin
            n_cur = 3'(MAX_USED);
        end
        cell_now = (below_reg == 3'd0) ? 3'd0 : (below_reg - 3'd1);
        if (cell_now > n_cur - 3'd2)
        begin
            cell_now = n_cur - 3'd2;
        end
    end

    always_comb
    begin
        case (axis_reg)
            3'd0:    x_cur = cmd_reg.word.query_x0;
            3'd1:    x_cur = cmd_reg.word.query_x1;
            3'd2:    x_cur = cmd_reg.word.query_x2;
            3'd3:    x_cur = cmd_reg.word.query_x3;
            3'd4:    x_cur = cmd_reg.word.query_x4;
            3'd5:    x_cur = cmd_reg.word.query_x5;
            default: x_cur = cmd_reg.word.query_x0;
        endcase
    end

    always_comb
    begin
        case (state_reg)
            S_PT_RD:   pt_sel = pt_reg;
            S_LFT_RD:  pt_sel = cell_now;
            S_LFT_USE: pt_sel = 3'(cur_cell_reg) + 3'd1;
            default:   pt_sel = 3'(cur_cell_reg);
        endcase
    end

    assign coord_addr  = CA_W'(int'(axis_reg) * AXIS_POINTS + int'(pt_sel));
    assign coord_waddr = CA_W'(int'(cmd_reg.word.axis) * AXIS_POINTS
                               + int'(cmd_reg.word.point_index));
    assign coord_we    = (state_reg == S_DISPATCH) && (cmd_reg.op == OP_COORD);

    // Table index of the current corner: corner bit 5 belongs to axis 0.
    always_comb
    begin
        for (int a = 0; a < NUM_AXES; a++)
        begin
            tidx[IDX_BITS*(NUM_AXES-1-a) +: IDX_BITS] =
                cell_reg[a] + IDX_BITS'(corner_reg[NUM_AXES-1-a]);
        end
    end

    assign tab_we   = (state_reg == S_DISPATCH) && (cmd_reg.op == OP_TABLE);
    assign tab_re   = (state_reg == S_C_START);
    assign tab_addr = tab_we ? cmd_reg.word.table_address : tidx;

    assign wsel = corner_reg[3'(NUM_AXES - 1) - step_reg] ? wr_reg[step_reg]
                                                         : wl_reg[step_reg];

    assign wl_new = (state_reg == S_DIV) ? div_quot : ONE;
    assign wr_new = sat32(WIDE_W'(ONE) - WIDE_W'(wl_new));

    assign div_num   = (DATA_W+1)'(coord_q_reg) - (DATA_W+1)'(x_cur);
    assign div_den   = (DATA_W+1)'(coord_q_reg) - (DATA_W+1)'(lft_reg);
    assign div_start = (state_reg == S_RGT_USE) && (coord_q_reg != lft_reg);

    assign pop = (state_reg == S_IDLE) && !q_status.empty;

    hgi_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_ff @(posedge clk)
    begin
        if (coord_we)
        begin
            coord_mem[coord_waddr] <= cmd_reg.word.write_value;
        end
        coord_q_reg <= coord_mem[coord_addr];
    end

    always_ff @(posedge clk)
    begin
        if (tab_we)
        begin
            table_mem[tab_addr] <= cmd_reg.word.write_value;
        end
        else if (tab_re)
        begin
            tab_q_reg <= table_mem[tab_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            result_valid_reg <= 1'b0;
            axis_reg         <= '0;
            pt_reg           <= '0;
            below_reg        <= '0;
            corner_reg       <= '0;
            step_reg         <= '0;
            extra_reg        <= 1'b0;
            degen_reg        <= 1'b0;
        end
        else
        begin
            result_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (!q_status.empty)
                    begin
                        cmd_reg   <= q_head;
                        state_reg <= S_DISPATCH;
                    end
                end
                S_DISPATCH:
                begin
                    axis_reg  <= '0;
                    pt_reg    <= '0;
                    below_reg <= '0;
                    extra_reg <= 1'b0;
                    degen_reg <= 1'b0;
                    acc_reg   <= '0;
                    state_reg <= (cmd_reg.op == OP_QUERY) ? S_PT_RD : S_IDLE;
                end
                S_PT_RD:
                begin
                    state_reg <= S_PT_USE;
                end
                S_PT_USE:
                begin
                    if (coord_q_reg < x_cur)
                    begin
                        below_reg <= below_reg + 3'd1;
                    end
                    if ((pt_reg == 3'd0) && (x_cur < coord_q_reg))
                    begin
                        extra_reg <= 1'b1;
                    end
                    if ((pt_reg == n_cur - 3'd1) && (x_cur > coord_q_reg))
                    begin
                        extra_reg <= 1'b1;
                    end
                    pt_reg    <= pt_reg + 3'd1;
                    state_reg <= (pt_reg == n_cur - 3'd1) ? S_LFT_RD : S_PT_RD;
                end
                S_LFT_RD:
                begin
                    cur_cell_reg       <= cell_now[1:0];
                    cell_reg[axis_reg] <= cell_now[1:0];
                    state_reg          <= S_LFT_USE;
                end
                S_LFT_USE:
                begin
                    lft_reg   <= coord_q_reg;
                    state_reg <= S_RGT_USE;
                end
                S_RGT_USE:
                begin
                    if (coord_q_reg == lft_reg)
                    begin
                        degen_reg        <= 1'b1;
                        wl_reg[axis_reg] <= wl_new;
                        wr_reg[axis_reg] <= wr_new;
                        state_reg        <= S_AXIS_END;
                    end
                    else
                    begin
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        wl_reg[axis_reg] <= wl_new;
                        wr_reg[axis_reg] <= wr_new;
                        state_reg        <= S_AXIS_END;
                    end
                end
                S_AXIS_END:
                begin
                    axis_reg  <= axis_reg + 3'd1;
                    pt_reg    <= '0;
                    below_reg <= '0;
                    if (axis_reg == 3'(NUM_AXES - 1))
                    begin
                        corner_reg <= '0;
                        step_reg   <= '0;
                        state_reg  <= S_C_START;
                    end
                    else
                    begin
                        state_reg <= S_PT_RD;
                    end
                end
                S_C_START:
                begin
                    w_reg     <= wsel;
                    step_reg  <= 3'd1;
                    state_reg <= S_C_MUL;
                end
                S_C_MUL:
                begin
                    w_reg <= sat32(qmul(w_reg, wsel));
                    if (step_reg == 3'(NUM_AXES - 1))
                    begin
                        step_reg  <= '0;
                        state_reg <= S_C_ACC;
                    end
                    else
                    begin
                        step_reg <= step_reg + 3'd1;
                    end
                end
                S_C_ACC:
                begin
                    acc_reg    <= acc_reg + ACCW'(qmul(tab_q_reg, w_reg));
                    corner_reg <= corner_reg + 6'd1;
                    state_reg  <= (corner_reg == 6'd63) ? S_DONE : S_C_START;
                end
                S_DONE:
                begin
                    result_valid_reg           <= 1'b1;
                    result_reg.interpolated    <= sat32(WIDE_W'(acc_reg));
                    result_reg.extrapolated    <= extra_reg;
                    result_reg.degenerate_cell <= degen_reg;
                    state_reg                  <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // A query yields a single result strobe, never two in a row.
    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |=> !result_valid_reg)
        else $error("result strobe held for more than one cycle");

    // The divider only runs while the sequencer waits on it.
    a_div_owned: assert property (@(posedge clk) disable iff (!rst_n)
        div_busy |-> (state_reg == S_DIV))
        else $error("divider running outside the weight step");

    // The result is formed only after all six axes were resolved.
    a_axes_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |-> (axis_reg == 3'(NUM_AXES)))
        else $error("result formed before all axes were resolved");

    // Nothing is popped while a command is still being carried out.
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (state_reg == S_DISPATCH))
        else $error("queue pop did not start a dispatch");

endmodule

// ===== hdl/hexalinear_grid_interpolator_unit.sv =====
// ============================================================================
// Hexalinear grid interpolator
// Six-axis multilinear interpolation over a loaded grid, in fixed point.
// ============================================================================
// Usage: a command word on item is taken at a clock edge where start is high
// and busy is low. Action 0 stores an axis coordinate, action 1 stores a
// table value, action 2 runs a query; other words are dropped. Words pass a
// two-word queue, so busy rises only while that queue is full.
// A write is stored when the sequencer dispatches it and gives no result.
// A query gives one word on result, marked by result_valid for one cycle;
// the receiver cannot hold it off. Per axis the sequencer reads each grid
// point through the coordinate memory port and, unless the cell is degenerate,
// runs a bit-serial divider of FRAC_BITS + 34 steps; then the 64 corners are
// weighted and summed one at a time through the multiplier and the table
// memory port.
// Point-count registers are written through cfg_we, cfg_index and cfg_data
// and reset to four. Reset empties the queue and the sequencer; coordinate
// and table storage is not cleared and must be written before use.
// ============================================================================
module hexalinear_grid_interpolator_unit import hgi_pkg::*;
#(
    parameter int AXIS_POINTS = DEF_AXIS_POINTS,
    parameter int FRAC_BITS   = DEF_FRAC_BITS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  in_word_t             item,
    output logic                 result_valid,
    output out_word_t            result,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    points_t       points_reg;
    logic          push;
    cmd_t          push_cmd;
    logic          pop;
    cmd_t          head;
    queue_status_t q_status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < NUM_AXES; a++)
            begin
                points_reg[a] <= POINTS_RESET;
            end
        end
        else if (cfg_we && (int'(cfg_index) < NUM_AXES))
        begin
            points_reg[cfg_index] <= cfg_data;
        end
    end

    assign busy = q_status.full;

    hgi_front #(
        .AXIS_POINTS (AXIS_POINTS)
    ) u_front (
        .start (start),
        .busy  (busy),
        .item  (item),
        .push  (push),
        .cmd   (push_cmd)
    );

    hgi_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .status   (q_status)
    );

    hgi_back #(
        .AXIS_POINTS (AXIS_POINTS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_status     (q_status),
        .q_head       (head),
        .pop          (pop),
        .points       (points_reg),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule
